@@ rtl/core/multilevel_active_expired_queue_assert.svh @@
// assertion macros for the active/expired ready queue block
`ifndef MULTILEVEL_ACTIVE_EXPIRED_QUEUE_ASSERT_SVH
`define MULTILEVEL_ACTIVE_EXPIRED_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
// concurrent check, switched off while reset is asserted
`define MAEQ_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("maeq assertion failed");
// concurrent check that also holds through reset
`define MAEQ_ASSERT_NR(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("maeq assertion failed");
`else
`define MAEQ_ASSERT(lbl, ck, rn, prop)
`define MAEQ_ASSERT_NR(lbl, ck, prop)
`endif
`endif

@@ rtl/core/maeq_pkg.sv @@
// shared constants, codes and control types of the active/expired ready queue
package maeq_pkg;

	localparam int LEVELS      = 4;
	localparam int QUEUE_DEPTH = 4;   // power of two: slot index wraps naturally
	localparam int ID_W        = 8;

	localparam int NQ          = 2 * LEVELS;
	localparam int LVL_W       = $clog2(LEVELS);
	localparam int Q_W         = LVL_W + 1;
	localparam int HD_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = Q_W + HD_W;
	localparam int STORE_DEPTH = NQ * QUEUE_DEPTH;

	localparam int CFG_W       = 3;
	localparam int PRIO_W      = 3;
	localparam int TGT_W       = PRIO_W + 1;
	localparam int SLVL_W      = 2;
	localparam int STAT_W      = 2;

	localparam logic [CFG_W-1:0] LEVELS_RESET = 3'd4;

	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TAKE = 1'b1;

	localparam logic [STAT_W-1:0] ADD_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ADD_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ADD_RANGE = 2'd2;

	typedef struct packed {
		logic req_ready;
		logic capture;
		logic exec;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic req_valid;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/maeq_if.sv @@
// request and response channel interfaces
interface maeq_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [maeq_pkg::ID_W-1:0]    task_id;
	logic signed [maeq_pkg::PRIO_W-1:0] dyn_prio;
	logic [maeq_pkg::PRIO_W-1:0]  static_prio;

	modport source (output valid, func, task_id, dyn_prio, static_prio, input ready);
	modport sink   (input valid, func, task_id, dyn_prio, static_prio, output ready);
endinterface

interface maeq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [maeq_pkg::ID_W-1:0]    granted_id;
	logic                         granted_valid;
	logic [maeq_pkg::SLVL_W-1:0]  stored_level;
	logic                         went_expired;
	logic                         banks_swapped;
	logic [maeq_pkg::STAT_W-1:0]  add_status;

	modport source (output valid, granted_id, granted_valid, stored_level, went_expired,
		banks_swapped, add_status, input ready);
	modport sink   (input valid, granted_id, granted_valid, stored_level, went_expired,
		banks_swapped, add_status, output ready);
endinterface

@@ rtl/core/maeq_ctrl.sv @@
// sequencing state machine: capture, execute, hand result to the output register
`include "multilevel_active_expired_queue_assert.svh"
module maeq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  maeq_pkg::sts_t sts,
	output maeq_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				cmd.capture   = sts.req_valid;
				if (sts.req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				// wait for room in the output register
				cmd.load_out = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`MAEQ_ASSERT(a_accept_to_exec, clk, arst_n, (sts.req_valid && cmd.req_ready) |=> (state_q == ST_EXEC))
	`MAEQ_ASSERT(a_exec_to_resp, clk, arst_n, cmd.exec |=> (state_q == ST_RESP && !cmd.req_ready))

endmodule

@@ rtl/core/maeq_dp.sv @@
// queue state, id store, level search and result registers
`include "multilevel_active_expired_queue_assert.svh"
module maeq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [maeq_pkg::CFG_W-1:0]   cfg_wdata,
	input  maeq_pkg::cmd_t               cmd,
	output maeq_pkg::sts_t               sts,
	maeq_req_if.sink                     req,
	maeq_rsp_if.source                   rsp
);

	// captured request
	logic                              func_q;
	logic [maeq_pkg::ID_W-1:0]         id_q;
	logic [maeq_pkg::PRIO_W-1:0]       dyn_q;
	logic [maeq_pkg::PRIO_W-1:0]       stat_q;

	// queue state
	logic [maeq_pkg::CFG_W-1:0]        lvl_q;
	logic [maeq_pkg::HD_W-1:0]         head_q  [maeq_pkg::NQ];
	logic [maeq_pkg::CNT_W-1:0]        count_q [maeq_pkg::NQ];
	logic                              active_q;
	logic [maeq_pkg::ID_W-1:0]         store_q [maeq_pkg::STORE_DEPTH];
	logic [maeq_pkg::ID_W-1:0]         rdata_q;

	// pending result
	logic                              r_gvalid_q;
	logic                              r_swap_q;
	logic [maeq_pkg::SLVL_W-1:0]       r_level_q;
	logic                              r_exp_q;
	logic [maeq_pkg::STAT_W-1:0]       r_status_q;

	// output register
	logic                              out_valid_q;
	logic [maeq_pkg::ID_W-1:0]         out_id_q;
	logic                              out_gvalid_q;
	logic [maeq_pkg::SLVL_W-1:0]       out_level_q;
	logic                              out_exp_q;
	logic                              out_swap_q;
	logic [maeq_pkg::STAT_W-1:0]       out_status_q;

	logic [maeq_pkg::CFG_W-1:0]        eff_lvl;
	logic                              expired;
	logic [maeq_pkg::TGT_W-1:0]        tgt_lvl;
	logic                              oor;
	logic [maeq_pkg::Q_W-1:0]          add_q;
	logic                              full;
	logic                              add_ok;
	logic [maeq_pkg::HD_W-1:0]         slot;
	logic                              found_a, found_o, take_found;
	logic [maeq_pkg::LVL_W-1:0]        lvl_a, lvl_o;
	logic [maeq_pkg::Q_W-1:0]          take_q;
	logic                              is_add, is_take;

	assign req.ready     = cmd.req_ready;
	assign sts.req_valid = req.valid;
	assign sts.out_free  = !out_valid_q || rsp.ready;

	assign is_add  = (func_q == maeq_pkg::FUNC_ADD);
	assign is_take = (func_q == maeq_pkg::FUNC_TAKE);

	// a register above the level count acts as the level count
	assign eff_lvl = (lvl_q > maeq_pkg::CFG_W'(maeq_pkg::LEVELS)) ?
		maeq_pkg::CFG_W'(maeq_pkg::LEVELS) : lvl_q;

	// negative dynamic priority goes to static - 1 in the expired bank;
	// static zero wraps high and so falls out of range
	assign expired = dyn_q[maeq_pkg::PRIO_W-1];
	assign tgt_lvl = expired ? ({1'b0, stat_q} - maeq_pkg::TGT_W'(1)) : {1'b0, dyn_q};
	assign oor     = tgt_lvl >= {1'b0, eff_lvl};
	assign add_q   = {active_q ^ expired, tgt_lvl[maeq_pkg::LVL_W-1:0]};
	assign full    = count_q[add_q] >= maeq_pkg::CNT_W'(maeq_pkg::QUEUE_DEPTH);
	assign add_ok  = !oor && !full;
	assign slot    = head_q[add_q] + count_q[add_q][maeq_pkg::HD_W-1:0];

	// highest non-empty level in use, for both banks
	always_comb begin
		found_a = 1'b0;
		found_o = 1'b0;
		lvl_a   = '0;
		lvl_o   = '0;
		for (int l = 0; l < maeq_pkg::LEVELS; l++) begin
			if (maeq_pkg::CFG_W'(l) < eff_lvl) begin
				if (count_q[{active_q, maeq_pkg::LVL_W'(l)}] != '0) begin
					found_a = 1'b1;
					lvl_a   = maeq_pkg::LVL_W'(l);
				end
				if (count_q[{~active_q, maeq_pkg::LVL_W'(l)}] != '0) begin
					found_o = 1'b1;
					lvl_o   = maeq_pkg::LVL_W'(l);
				end
			end
		end
	end

	assign take_found = found_a || found_o;
	assign take_q     = found_a ? {active_q, lvl_a} : {~active_q, lvl_o};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req.func;
			id_q   <= req.task_id;
			dyn_q  <= req.dyn_prio;
			stat_q <= req.static_prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q    <= maeq_pkg::LEVELS_RESET;
			active_q <= 1'b0;
			for (int q = 0; q < maeq_pkg::NQ; q++) begin
				head_q[q]  <= '0;
				count_q[q] <= '0;
			end
		end else begin
			if (cfg_we) begin
				lvl_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				if (is_add) begin
					if (add_ok) begin
						count_q[add_q] <= count_q[add_q] + maeq_pkg::CNT_W'(1);
					end
				end else begin
					if (!found_a) begin
						active_q <= ~active_q;
					end
					if (take_found) begin
						head_q[take_q]  <= head_q[take_q] + maeq_pkg::HD_W'(1);
						count_q[take_q] <= count_q[take_q] - maeq_pkg::CNT_W'(1);
					end
				end
			end
		end
	end

	// id store: one write or one registered read per request
	always_ff @(posedge clk) begin
		if (cmd.exec && is_add && add_ok) begin
			store_q[{add_q, slot}] <= id_q;
		end
		if (cmd.exec && is_take) begin
			rdata_q <= store_q[{take_q, head_q[take_q]}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			r_gvalid_q <= is_take && take_found;
			r_swap_q   <= is_take && !found_a;
			r_level_q  <= (is_add && add_ok) ? tgt_lvl[maeq_pkg::SLVL_W-1:0] : '0;
			r_exp_q    <= is_add && add_ok && expired;
			if (!is_add) begin
				r_status_q <= maeq_pkg::ADD_OK;
			end else if (oor) begin
				r_status_q <= maeq_pkg::ADD_RANGE;
			end else if (full) begin
				r_status_q <= maeq_pkg::ADD_FULL;
			end else begin
				r_status_q <= maeq_pkg::ADD_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_id_q     <= r_gvalid_q ? rdata_q : '0;
			out_gvalid_q <= r_gvalid_q;
			out_level_q  <= r_level_q;
			out_exp_q    <= r_exp_q;
			out_swap_q   <= r_swap_q;
			out_status_q <= r_status_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_id    = out_id_q;
	assign rsp.granted_valid = out_gvalid_q;
	assign rsp.stored_level  = out_level_q;
	assign rsp.went_expired  = out_exp_q;
	assign rsp.banks_swapped = out_swap_q;
	assign rsp.add_status    = out_status_q;

	`MAEQ_ASSERT(a_no_overwrite, clk, arst_n, cmd.load_out |-> (!out_valid_q || rsp.ready))
	`MAEQ_ASSERT(a_swap_flips, clk, arst_n, (cmd.exec && is_take && !found_a) |=> (active_q != $past(active_q)))
	`MAEQ_ASSERT(a_grant_status, clk, arst_n, (rsp.valid && rsp.granted_valid) |-> (rsp.add_status == maeq_pkg::ADD_OK && !rsp.went_expired))
	`MAEQ_ASSERT_NR(a_reset_empty, clk, !arst_n |-> !out_valid_q)

endmodule

@@ rtl/core/multilevel_active_expired_queue.sv @@
// top level of the two-bank active/expired multilevel ready queue
//
// channel  dir  handshake      payload
// req      in   valid/ready    func, task_id, dyn_prio, static_prio
// rsp      out  valid/ready    granted_id, granted_valid, stored_level,
//                              went_expired, banks_swapped, add_status
// cfg      in   cfg_we         cfg_wdata (levels_in_use)
//
// each request goes through capture, queue update with a registered
// read of the id store, then load of the output register
// a new request is taken while the previous response still waits in the
// output register; a stalled output holds the controller in its response step
// arst_n clears all queue counts and heads, the active bank and the state
// machine at once; the id store needs no clearing since only counted entries
// ever reach the output
`include "multilevel_active_expired_queue_assert.svh"
module multilevel_active_expired_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [maeq_pkg::CFG_W-1:0] cfg_wdata,
	maeq_req_if.sink                   req,
	maeq_rsp_if.source                 rsp
);

	// command and status between the sequencer and the datapath
	maeq_pkg::cmd_t cmd;
	maeq_pkg::sts_t sts;

	// state machine: idle takes a request, execute updates the queues,
	// response waits for a free output register
	maeq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// per-level fifo counters and heads for both banks, the id store,
	// the level search and the output register
	maeq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp)
	);

	// a request is never taken unless the sequencer is idle
	`MAEQ_ASSERT(a_req_one_at_a_time, clk, arst_n, (req.valid && req.ready) |=> !req.ready)
	`MAEQ_ASSERT(a_load_after_accept, clk, arst_n, (req.valid && req.ready) |=> !cmd.load_out)

endmodule
